// ===== hdl/gds_pkg.sv =====
// Shared constants, register codes and types of the grid diffusion stencil.
package gds_pkg;

	localparam int VALUE_BITS_DEFAULT  = 32;
	localparam int FACTOR_BITS_DEFAULT = 16;
	localparam int MAX_WIDTH_DEFAULT   = 1024;

	localparam int CFG_DIM_BITS   = 11;
	localparam int CFG_INDEX_BITS = 2;

	localparam int GRID_WIDTH_RESET  = 64;
	localparam int GRID_HEIGHT_RESET = 64;
	localparam int FACTOR_RESET      = 26214;

	localparam int NEIGHBOR_SHARES = 4;
	localparam int SHARE_BITS      = $clog2(NEIGHBOR_SHARES);
	localparam int COUNT_BITS      = $clog2(NEIGHBOR_SHARES + 1);

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_GRID_WIDTH       = 2'd0,
		REG_GRID_HEIGHT      = 2'd1,
		REG_DIFFUSION_FACTOR = 2'd2
	} gds_reg_t;

	typedef struct packed {
		logic emit;
		logic has_up;
		logic has_left;
		logic has_right;
		logic has_down;
		logic last_cell;
	} gds_tap_t;

endpackage

// ===== hdl/gds_stream_ifs.sv =====
// Valid/ready stream interfaces for grid cells and diffused results.
interface gds_cell_if #(
	parameter int VALUE_BITS = gds_pkg::VALUE_BITS_DEFAULT
);
	logic                         valid;
	logic                         ready;
	logic                         mode;
	logic signed [VALUE_BITS-1:0] cell_value;

	modport source (output valid, output mode, output cell_value, input ready);
	modport sink (input valid, input mode, input cell_value, output ready);
endinterface

interface gds_result_if #(
	parameter int VALUE_BITS = gds_pkg::VALUE_BITS_DEFAULT
);
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] new_value;
	logic                         last_cell;

	modport source (output valid, output new_value, output last_cell, input ready);
	modport sink (input valid, input new_value, input last_cell, output ready);
endinterface

// ===== hdl/gds_line_mem.sv =====
// Two-row line memory with registered reads and write-to-read forwarding.
module gds_line_mem #(
	parameter int DEPTH      = gds_pkg::MAX_WIDTH_DEFAULT,
	parameter int VALUE_BITS = gds_pkg::VALUE_BITS_DEFAULT,
	localparam int AW        = $clog2(DEPTH)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [AW-1:0]                rd_addr,
	input  logic [AW-1:0]                rd_addr_next,
	input  logic                         wr_en,
	input  logic [AW-1:0]                wr_addr,
	input  logic signed [VALUE_BITS-1:0] wr_row1,
	input  logic signed [VALUE_BITS-1:0] wr_row2,
	output logic signed [VALUE_BITS-1:0] center,
	output logic signed [VALUE_BITS-1:0] right,
	output logic signed [VALUE_BITS-1:0] up
);
	import gds_pkg::*;

	logic signed [VALUE_BITS-1:0] row1_mem [DEPTH];
	logic signed [VALUE_BITS-1:0] row2_mem [DEPTH];

	logic signed [VALUE_BITS-1:0] center_s1, right_s1, up_s1;
	logic signed [VALUE_BITS-1:0] fwd_row1_s1, fwd_row2_s1;
	logic                         fwd_cur_s1, fwd_next_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			row1_mem[wr_addr] <= wr_row1;
			row2_mem[wr_addr] <= wr_row2;
		end
		if (rd_en) begin
			center_s1   <= row1_mem[rd_addr];
			up_s1       <= row2_mem[rd_addr];
			right_s1    <= row1_mem[rd_addr_next];
			fwd_row1_s1 <= wr_row1;
			fwd_row2_s1 <= wr_row2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_cur_s1  <= 1'b0;
			fwd_next_s1 <= 1'b0;
		end else if (rd_en) begin
			fwd_cur_s1  <= wr_en && (wr_addr == rd_addr);
			fwd_next_s1 <= wr_en && (wr_addr == rd_addr_next);
		end
	end

	assign center = fwd_cur_s1 ? fwd_row1_s1 : center_s1;
	assign up     = fwd_cur_s1 ? fwd_row2_s1 : up_s1;
	assign right  = fwd_next_s1 ? fwd_row1_s1 : right_s1;

endmodule

// ===== hdl/gds_ctrl.sv =====
// Configuration registers, raster counters and neighbor selection per cell.
module gds_ctrl #(
	parameter int MAX_WIDTH      = gds_pkg::MAX_WIDTH_DEFAULT,
	parameter int FACTOR_BITS    = gds_pkg::FACTOR_BITS_DEFAULT,
	localparam int AW            = $clog2(MAX_WIDTH),
	localparam int CFG_DATA_BITS = (FACTOR_BITS > gds_pkg::CFG_DIM_BITS) ?
		FACTOR_BITS : gds_pkg::CFG_DIM_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [gds_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0]            cfg_data,
	input  logic                                cell_valid,
	input  logic                                cell_mode,
	input  logic                                s1_ready,
	output logic                                take,
	output gds_pkg::gds_tap_t                   tap,
	output logic [AW-1:0]                       rd_addr,
	output logic [AW-1:0]                       rd_addr_next,
	output logic [FACTOR_BITS-1:0]              factor
);
	import gds_pkg::*;

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int LW = (WW > CFG_DIM_BITS) ? WW : CFG_DIM_BITS;

	logic [CFG_DIM_BITS-1:0] grid_width_q, grid_height_q;
	logic [FACTOR_BITS-1:0]  factor_q;
	logic [CFG_DIM_BITS-1:0] row_q;
	logic [AW-1:0]           col_q;

	logic [LW-1:0]           width_ext, width_eff, col_inc;
	logic [CFG_DIM_BITS-1:0] height_eff;
	logic                    all_rows, last_col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= CFG_DIM_BITS'(GRID_WIDTH_RESET);
			grid_height_q <= CFG_DIM_BITS'(GRID_HEIGHT_RESET);
			factor_q      <= FACTOR_BITS'(FACTOR_RESET);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_GRID_WIDTH:       grid_width_q  <= cfg_data[CFG_DIM_BITS-1:0];
				REG_GRID_HEIGHT:      grid_height_q <= cfg_data[CFG_DIM_BITS-1:0];
				REG_DIFFUSION_FACTOR: factor_q      <= cfg_data[FACTOR_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		width_ext = LW'(grid_width_q);
		if (width_ext == '0) begin
			width_eff = LW'(1);
		end else if (width_ext > LW'(MAX_WIDTH)) begin
			width_eff = LW'(MAX_WIDTH);
		end else begin
			width_eff = width_ext;
		end
		height_eff = (grid_height_q == '0) ? CFG_DIM_BITS'(1) : grid_height_q;
		col_inc    = LW'(col_q) + LW'(1);
		last_col   = col_inc >= width_eff;
		all_rows   = row_q >= height_eff;
	end

	assign take = cell_valid && s1_ready && (cell_mode == all_rows);

	always_comb begin
		tap.emit      = row_q != '0;
		tap.has_up    = row_q >= CFG_DIM_BITS'(2);
		tap.has_left  = col_q != '0;
		tap.has_right = !last_col;
		tap.has_down  = !cell_mode;
		tap.last_cell = cell_mode && last_col;
	end

	assign rd_addr      = col_q;
	assign rd_addr_next = (col_q == AW'(MAX_WIDTH - 1)) ? '0 : col_q + AW'(1);
	assign factor       = factor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (take) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= cell_mode ? '0 : row_q + CFG_DIM_BITS'(1);
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

endmodule

// ===== hdl/gds_datapath.sv =====
// Stencil arithmetic pipeline: neighbor sum, scaling product, saturation, output.
module gds_datapath #(
	parameter int MAX_WIDTH   = gds_pkg::MAX_WIDTH_DEFAULT,
	parameter int VALUE_BITS  = gds_pkg::VALUE_BITS_DEFAULT,
	parameter int FACTOR_BITS = gds_pkg::FACTOR_BITS_DEFAULT,
	localparam int AW         = $clog2(MAX_WIDTH)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         take,
	input  gds_pkg::gds_tap_t            tap,
	input  logic [AW-1:0]                rd_addr,
	input  logic signed [VALUE_BITS-1:0] cell_value,
	input  logic [FACTOR_BITS-1:0]       factor,
	input  logic signed [VALUE_BITS-1:0] center,
	input  logic signed [VALUE_BITS-1:0] right,
	input  logic signed [VALUE_BITS-1:0] up,
	output logic                         s1_ready,
	output logic                         wr_en,
	output logic [AW-1:0]                wr_addr,
	output logic signed [VALUE_BITS-1:0] wr_row1,
	output logic signed [VALUE_BITS-1:0] wr_row2,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [VALUE_BITS-1:0] new_value,
	output logic                         last_cell
);
	import gds_pkg::*;

	localparam int DW    = VALUE_BITS + 4;
	localparam int PW    = DW + FACTOR_BITS + 1;
	localparam int SHIFT = FACTOR_BITS + SHARE_BITS;
	localparam int QW    = PW - SHIFT;
	localparam int RW    = VALUE_BITS + 4;

	logic ld_out, ld3, ld2;

	logic                         s1_v;
	gds_tap_t                     tap_s1;
	logic [AW-1:0]                addr_s1;
	logic signed [VALUE_BITS-1:0] cell_s1;
	logic signed [VALUE_BITS-1:0] left_q;

	logic                         s2_v;
	logic signed [DW-1:0]         diff_s2;
	logic signed [VALUE_BITS-1:0] center_s2;
	logic                         last_s2;

	logic                         s3_v;
	logic signed [PW-1:0]         prod_s3;
	logic signed [VALUE_BITS-1:0] center_s3;
	logic                         last_s3;

	logic                         out_v_q;
	logic signed [VALUE_BITS-1:0] value_q;
	logic                         last_q;

	logic signed [DW-1:0]         up_t, left_t, right_t, down_t, center_t, sum, nv, diff;
	logic [COUNT_BITS-1:0]        n;
	logic signed [FACTOR_BITS:0]  factor_s;
	logic signed [QW-1:0]         share;
	logic signed [RW-1:0]         total;
	logic                         in_range;
	logic signed [VALUE_BITS-1:0] sat;

	assign ld_out   = !out_v_q || out_ready;
	assign ld3      = !s3_v || ld_out;
	assign ld2      = !s2_v || ld3;
	assign s1_ready = !s1_v || ld2;

	// stage 1: neighbor sum against the memory read
	always_comb begin
		center_t = $signed({{(DW-VALUE_BITS){center[VALUE_BITS-1]}}, center});
		up_t     = tap_s1.has_up ?
			$signed({{(DW-VALUE_BITS){up[VALUE_BITS-1]}}, up}) : '0;
		left_t   = tap_s1.has_left ?
			$signed({{(DW-VALUE_BITS){left_q[VALUE_BITS-1]}}, left_q}) : '0;
		right_t  = tap_s1.has_right ?
			$signed({{(DW-VALUE_BITS){right[VALUE_BITS-1]}}, right}) : '0;
		down_t   = tap_s1.has_down ?
			$signed({{(DW-VALUE_BITS){cell_s1[VALUE_BITS-1]}}, cell_s1}) : '0;
		sum      = up_t + left_t + right_t + down_t;
		n        = COUNT_BITS'(tap_s1.has_up) + COUNT_BITS'(tap_s1.has_left) +
			COUNT_BITS'(tap_s1.has_right) + COUNT_BITS'(tap_s1.has_down);
		case (n)
			COUNT_BITS'(1): nv = center_t;
			COUNT_BITS'(2): nv = center_t <<< 1;
			COUNT_BITS'(3): nv = center_t + (center_t <<< 1);
			COUNT_BITS'(4): nv = center_t <<< 2;
			default:        nv = '0;
		endcase
		diff = sum - nv;
	end

	assign wr_en   = s1_v && ld2;
	assign wr_addr = addr_s1;
	assign wr_row1 = tap_s1.has_down ? cell_s1 : center;
	assign wr_row2 = center;

	// stage 3: floor of the scaled difference, add back, saturate
	always_comb begin
		share    = $signed(prod_s3[PW-1:SHIFT]);
		total    = $signed({{(RW-VALUE_BITS){center_s3[VALUE_BITS-1]}}, center_s3}) +
			$signed({{(RW-QW){share[QW-1]}}, share});
		in_range = (&total[RW-1:VALUE_BITS-1]) || !(|total[RW-1:VALUE_BITS-1]);
		if (in_range) begin
			sat = total[VALUE_BITS-1:0];
		end else if (total[RW-1]) begin
			sat = $signed({1'b1, {(VALUE_BITS-1){1'b0}}});
		end else begin
			sat = $signed({1'b0, {(VALUE_BITS-1){1'b1}}});
		end
	end

	assign factor_s = $signed({1'b0, factor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v    <= 1'b0;
			s2_v    <= 1'b0;
			s3_v    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s1_ready) s1_v <= take;
			if (ld2) s2_v <= s1_v && tap_s1.emit;
			if (ld3) s3_v <= s2_v;
			if (ld_out) out_v_q <= s3_v;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready) begin
			tap_s1  <= tap;
			addr_s1 <= rd_addr;
			cell_s1 <= cell_value;
		end
		if (wr_en) left_q <= center;
		if (ld2) begin
			diff_s2   <= diff;
			center_s2 <= center;
			last_s2   <= tap_s1.last_cell;
		end
		if (ld3) begin
			prod_s3   <= diff_s2 * factor_s;
			center_s3 <= center_s2;
			last_s3   <= last_s2;
		end
		if (ld_out) begin
			value_q <= sat;
			last_q  <= last_s3;
		end
	end

	assign out_valid = out_v_q;
	assign new_value = value_q;
	assign last_cell = last_q;

endmodule

// ===== hdl/grid_diffusion_stencil.sv =====
// Top level of the grid diffusion stencil.
// One diffusion step over a raster-order grid, one cell accepted per clock cycle
// when the result side keeps up; each result passes the s1, s2, s3 and output
// registers after the cell that completes it is accepted, and output runs one row
// behind input, so flush items (mode 1) drain the final row. The rate is set by one
// read-modify-write of the dual-row line memory per cell, with same-cycle write
// forwarding; the memory needs no clearing pass after reset.
module grid_diffusion_stencil #(
	parameter int MAX_WIDTH      = gds_pkg::MAX_WIDTH_DEFAULT,
	parameter int VALUE_BITS     = gds_pkg::VALUE_BITS_DEFAULT,
	parameter int FACTOR_BITS    = gds_pkg::FACTOR_BITS_DEFAULT,
	localparam int CFG_DATA_BITS = (FACTOR_BITS > gds_pkg::CFG_DIM_BITS) ?
		FACTOR_BITS : gds_pkg::CFG_DIM_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [gds_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]           cfg_data,
	gds_cell_if.sink                           cells,
	gds_result_if.source                       results
);
	import gds_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);

	logic                         take, s1_ready, wr_en;
	gds_tap_t                     tap;
	logic [AW-1:0]                rd_addr, rd_addr_next, wr_addr;
	logic [FACTOR_BITS-1:0]       factor;
	logic signed [VALUE_BITS-1:0] center, right, up, wr_row1, wr_row2;

	gds_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.FACTOR_BITS(FACTOR_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cell_valid  (cells.valid),
		.cell_mode   (cells.mode),
		.s1_ready    (s1_ready),
		.take        (take),
		.tap         (tap),
		.rd_addr     (rd_addr),
		.rd_addr_next(rd_addr_next),
		.factor      (factor)
	);

	gds_line_mem #(
		.DEPTH     (MAX_WIDTH),
		.VALUE_BITS(VALUE_BITS)
	) u_line_mem (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_en       (s1_ready),
		.rd_addr     (rd_addr),
		.rd_addr_next(rd_addr_next),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_row1     (wr_row1),
		.wr_row2     (wr_row2),
		.center      (center),
		.right       (right),
		.up          (up)
	);

	gds_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.VALUE_BITS (VALUE_BITS),
		.FACTOR_BITS(FACTOR_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.tap       (tap),
		.rd_addr   (rd_addr),
		.cell_value(cells.cell_value),
		.factor    (factor),
		.center    (center),
		.right     (right),
		.up        (up),
		.s1_ready  (s1_ready),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_row1   (wr_row1),
		.wr_row2   (wr_row2),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.new_value (results.new_value),
		.last_cell (results.last_cell)
	);

	assign cells.ready = s1_ready;

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!results.valid |-> cells.ready)
		else $error("input stalled with an empty result register");

	a_take_matches_mode: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> (cells.valid && cells.ready && (cells.mode == !tap.has_down)))
		else $error("transaction taken without a matching handshake");

	a_right_is_next_column: assert property (@(posedge clk) disable iff (!arst_n)
		(take && tap.has_right) |-> (rd_addr_next == rd_addr + AW'(1)))
		else $error("right neighbor read from the wrong column");

endmodule
